[design/assert_macros.svh]
// Assertion helpers used by the step top design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/pmi_pkg.sv]
package pmi_pkg;

    localparam int W       = 32;
    localparam int F       = 16;
    localparam int DT_BITS = F + 4;
    localparam int NUM_AX  = 3;
    localparam int DIV_STEPS = 2 * W;
    localparam int SQRT_STEPS = W;

    localparam logic signed [W-1:0] S_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] S_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [2*W-1:0] MAG_MAX = {{(W+1){1'b0}}, {(W-1){1'b1}}};
    // round(9.81 * 2^F)
    localparam logic signed [W-1:0] GRAVITY = W'((981 * (64'(1) << F) + 50) / 100);

    // configuration register indexes
    localparam logic [2:0] CFG_MODE      = 3'd0;
    localparam logic [2:0] CFG_SPD_LIM   = 3'd1;
    localparam logic [2:0] CFG_MASS      = 3'd2;
    localparam logic [2:0] CFG_DRAG      = 3'd3;
    localparam logic [2:0] CFG_WIND_N    = 3'd4;
    localparam logic [2:0] CFG_WIND_E    = 3'd5;
    localparam logic [2:0] CFG_WIND_D    = 3'd6;
    localparam logic [2:0] CFG_FAI       = 3'd7;

    typedef enum logic [1:0] {
        CMD_SET_VEL   = 2'd0,
        CMD_SET_FORCE = 2'd1,
        CMD_TICK      = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [1:0]             command;
        logic signed [W-1:0]    vec_north;
        logic signed [W-1:0]    vec_east;
        logic signed [W-1:0]    vec_down;
        logic [DT_BITS-1:0]     time_step;
    } t_in;

    typedef struct packed {
        logic signed [W-1:0]    pos_north;
        logic signed [W-1:0]    pos_east;
        logic signed [W-1:0]    pos_down;
        logic signed [W-1:0]    vel_north;
        logic signed [W-1:0]    vel_east;
        logic signed [W-1:0]    vel_down;
        logic signed [W-1:0]    acc_north;
        logic signed [W-1:0]    acc_east;
        logic signed [W-1:0]    acc_down;
        logic                   on_ground;
        logic signed [W-1:0]    altitude;
        logic [W-2:0]           ground_speed;
    } t_out;

    typedef enum logic [4:0] {
        L_NOP, L_SETV, L_MUL_FORCE, L_SETF, L_MUL_DTV, L_POS, L_COPYV, L_MUL_SQ,
        L_MUL_CLAMP, L_DIV_CLAMP, L_CLAMP_DONE, L_MUL_DRAG, L_DIV_ACC, L_ACC_DONE,
        L_MUL_DTA, L_VEL, L_GROUND
    } t_lane_op;

    typedef struct packed {
        t_lane_op op;
        logic     ground;
    } t_lane_ctl;

    typedef struct packed {
        logic [W-2:0] mass;
        logic [W-2:0] mass_eff;
        logic [W-2:0] drag;
        logic [W-2:0] spd_lim;
        logic         fai;
    } t_lane_cfg;

    typedef struct packed {
        logic signed [W-1:0] pos;
        logic signed [W-1:0] vel;
        logic signed [W-1:0] acc;
        logic                dv_neg;
        logic                df_neg;
        logic                busy;
    } t_lane_stat;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_SETF, S_POS, S_COPYV, S_SQ1, S_NORM1_GO, S_NORM1_WAIT,
        S_CL_MUL, S_CL_DIV, S_CL_WAIT, S_DRAG_MUL, S_ACC_DIV, S_ACC_WAIT, S_DTA_MUL,
        S_VEL, S_GROUND, S_SQ2, S_NORM2_GO, S_NORM2_WAIT, S_OUT
    } t_state;

    function automatic logic [W-1:0] f_mag(logic signed [W-1:0] x);
        f_mag = x[W-1] ? (~x + 1'b1) : x;
    endfunction

    // magnitude plus sign back to a saturated signed word
    function automatic logic signed [W-1:0] f_sat_mag(logic neg, logic [2*W-1:0] m);
        logic [W-1:0] lo;
        lo = m[W-1:0];
        if (!neg) f_sat_mag = (m > MAG_MAX) ? S_MAX : lo;
        else      f_sat_mag = (m > MAG_MAX) ? S_MIN : (~lo + 1'b1);
    endfunction

    // fixed-point product scaling
    function automatic logic signed [W-1:0] f_fx(logic neg, logic [2*W-1:0] p);
        f_fx = f_sat_mag(neg, p >> F);
    endfunction

    function automatic logic signed [W-1:0] f_sat_add(logic signed [W-1:0] a,
                                                      logic signed [W-1:0] b);
        logic [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1]) f_sat_add = s[W] ? S_MIN : S_MAX;
        else                f_sat_add = s[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] f_sat_sub(logic signed [W-1:0] a,
                                                      logic signed [W-1:0] b);
        logic [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1]) f_sat_sub = s[W] ? S_MIN : S_MAX;
        else                f_sat_sub = s[W-1:0];
    endfunction

endpackage

[design/pmi_lane.sv]
module pmi_lane (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pmi_pkg::t_lane_ctl          i_ctl,
    input  pmi_pkg::t_lane_cfg          i_cfg,
    input  logic signed [pmi_pkg::W-1:0] i_vec,
    input  logic signed [pmi_pkg::W-1:0] i_wind,
    input  logic [pmi_pkg::DT_BITS-1:0] i_dt,
    input  logic [pmi_pkg::W-1:0]       i_norm,
    input  logic                        i_pin_pos,
    output logic [2*pmi_pkg::W-1:0]     o_prod,
    output pmi_pkg::t_lane_stat         o_stat
);
    import pmi_pkg::*;

    localparam int CNT_BITS = $clog2(DIV_STEPS + 1);

    logic signed [W-1:0] r_pos, r_vel, r_acc, r_dv, r_df;
    logic [2*W-1:0]      r_prod;
    logic                r_sign;
    logic [W-1:0]        r_dvsr, r_rem;
    logic [2*W-1:0]      r_quo;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy;

    logic [W-1:0]        mul_a, mul_b;
    logic                mul_neg, is_mul;
    logic signed [W-1:0] diff, num;
    logic [W:0]          div_t;
    logic                div_bit;

    // operand select for the lane multiplier
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        is_mul  = 1'b0;
        diff    = f_sat_sub(r_vel, i_wind);
        num     = f_sat_sub(r_df, f_fx(r_sign, r_prod));
        unique case (i_ctl.op)
            L_MUL_FORCE: begin
                mul_a = f_mag(i_vec); mul_b = {1'b0, i_cfg.mass};
                mul_neg = i_vec[W-1]; is_mul = 1'b1;
            end
            L_MUL_DTV: begin
                mul_a = W'(i_dt); mul_b = f_mag(r_vel);
                mul_neg = r_vel[W-1]; is_mul = 1'b1;
            end
            L_MUL_SQ: begin
                mul_a = f_mag(r_vel); mul_b = f_mag(r_vel); is_mul = 1'b1;
            end
            L_MUL_CLAMP: begin
                mul_a = f_mag(r_vel); mul_b = {1'b0, i_cfg.spd_lim};
                mul_neg = r_vel[W-1]; is_mul = 1'b1;
            end
            L_MUL_DRAG: begin
                mul_a = {1'b0, i_cfg.drag}; mul_b = f_mag(diff);
                mul_neg = diff[W-1]; is_mul = 1'b1;
            end
            L_MUL_DTA: begin
                mul_a = W'(i_dt); mul_b = f_mag(r_acc);
                mul_neg = r_acc[W-1]; is_mul = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // restoring divider step
    always_comb begin
        div_t   = {r_rem, r_quo[2*W-1]};
        div_bit = (div_t >= {1'b0, r_dvsr});
    end

    // lane state, multiplier and divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_vel  <= '0;
            r_acc  <= '0;
            r_dv   <= '0;
            r_df   <= '0;
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (is_mul) begin
                r_prod <= (2*W)'(mul_a) * (2*W)'(mul_b);
                r_sign <= mul_neg;
            end
            if (r_busy) begin
                r_rem  <= div_bit ? W'(div_t - {1'b0, r_dvsr}) : div_t[W-1:0];
                r_quo  <= {r_quo[2*W-2:0], div_bit};
                r_cnt  <= r_cnt - 1'b1;
                r_busy <= (r_cnt != CNT_BITS'(1));
            end
            unique case (i_ctl.op)
                L_SETV:  r_dv <= i_vec;
                L_SETF:  r_df <= i_cfg.fai ? f_fx(r_sign, r_prod) : i_vec;
                L_POS:   r_pos <= f_sat_add(r_pos, f_fx(r_sign, r_prod));
                L_COPYV: r_vel <= r_dv;
                L_DIV_CLAMP: begin
                    r_quo  <= r_prod;
                    r_dvsr <= i_norm;
                    r_rem  <= '0;
                    r_cnt  <= CNT_BITS'(DIV_STEPS);
                    r_busy <= 1'b1;
                end
                L_CLAMP_DONE: r_vel <= f_sat_mag(r_sign, r_quo);
                L_DIV_ACC: begin
                    r_quo  <= (2*W)'(f_mag(num)) << F;
                    r_sign <= num[W-1];
                    r_dvsr <= {1'b0, i_cfg.mass_eff};
                    r_rem  <= '0;
                    r_cnt  <= CNT_BITS'(DIV_STEPS);
                    r_busy <= 1'b1;
                end
                L_ACC_DONE: r_acc <= f_sat_mag(r_sign, r_quo);
                L_VEL:      r_vel <= f_sat_add(r_vel, f_fx(r_sign, r_prod));
                L_GROUND: begin
                    if (i_ctl.ground) begin
                        r_vel <= '0;
                        if (i_pin_pos) r_pos <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_prod = r_prod;
    always_comb begin
        o_stat.pos    = r_pos;
        o_stat.vel    = r_vel;
        o_stat.acc    = r_acc;
        o_stat.dv_neg = r_dv[W-1];
        o_stat.df_neg = r_df[W-1];
        o_stat.busy   = r_busy;
    end

endmodule

[design/pmi_norm.sv]
module pmi_norm (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_go,
    input  logic [2*pmi_pkg::W-1:0] i_sq0,
    input  logic [2*pmi_pkg::W-1:0] i_sq1,
    input  logic [2*pmi_pkg::W-1:0] i_sq2,
    output logic [pmi_pkg::W-1:0]   o_root,
    output logic                    o_busy
);
    import pmi_pkg::*;

    localparam int CNT_BITS = $clog2(SQRT_STEPS + 1);

    logic [2*W-1:0]      r_rad;
    logic [W+1:0]        r_rem;
    logic [W-1:0]        r_root;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy;

    logic [W+3:0] rem_sh, trial;
    logic         fits;

    // one root bit per cycle
    always_comb begin
        rem_sh = {r_rem, r_rad[2*W-1:2*W-2]};
        trial  = (W+4)'({r_root, 2'b01});
        fits   = (rem_sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_go) begin
            // sum of squares stays below 2^64 for three word magnitudes
            r_rad  <= i_sq0 + i_sq1 + i_sq2;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= CNT_BITS'(SQRT_STEPS);
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_rad  <= r_rad << 2;
            r_rem  <= fits ? (W+2)'(rem_sh - trial) : rem_sh[W+1:0];
            r_root <= {r_root[W-2:0], fits};
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != CNT_BITS'(1));
        end
    end

    assign o_root = r_root;
    assign o_busy = r_busy;

endmodule

[design/point_mass_integrator_step_top.sv]
// Set commands: velocity or force, from request back to idle with no result.
// Tick: one result per request, in single mode with or without the limit check and
// clamp or in double mode, built with the 64-step lane divider and the 32-step
// square root. One request at a time.
// Reset (i_rst_n low, synchronous): state vectors and ground latch cleared,
// registers back to their defaults, no result pending.
module point_mass_integrator_step_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pmi_pkg::t_in        i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pmi_pkg::t_out       o_out_data,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [pmi_pkg::W-1:0] i_cfg_data
);
    import pmi_pkg::*;

    // configuration registers
    logic                r_mode, r_fai;
    logic signed [W-1:0] r_spd_lim, r_wind_n, r_wind_e, r_wind_d;
    logic [W-2:0]        r_mass, r_drag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_spd_lim   <= -(W'(1) << F);
            r_mass      <= (W-1)'(4) << F;
            r_drag      <= (W-1)'(3277);
            r_wind_n    <= W'(1) << F;
            r_wind_e    <= '0;
            r_wind_d    <= '0;
            r_fai       <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE:      r_mode      <= i_cfg_data[0];
                CFG_SPD_LIM:   r_spd_lim   <= i_cfg_data;
                CFG_MASS:      r_mass      <= i_cfg_data[W-2:0];
                CFG_DRAG:      r_drag      <= i_cfg_data[W-2:0];
                CFG_WIND_N:    r_wind_n    <= i_cfg_data;
                CFG_WIND_E:    r_wind_e    <= i_cfg_data;
                CFG_WIND_D:    r_wind_d    <= i_cfg_data;
                CFG_FAI:       r_fai       <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    t_lane_cfg lane_cfg;
    always_comb begin
        lane_cfg.mass      = r_mass;
        lane_cfg.mass_eff  = (r_mass == '0) ? (W-1)'(1) : r_mass;
        lane_cfg.drag      = r_drag;
        lane_cfg.spd_lim   = r_spd_lim[W-2:0];
        lane_cfg.fai       = r_fai;
    end

    t_state              r_state, n_state;
    t_in                 r_item;
    logic                r_latch, n_latch;
    t_lane_ctl           ctl;
    logic                norm_go, load_out;
    t_lane_stat          st [NUM_AX];
    logic [2*W-1:0]      prod [NUM_AX];
    logic signed [W-1:0] vec [NUM_AX];
    logic signed [W-1:0] wind [NUM_AX];
    logic [W-1:0]        root;
    logic                norm_busy, lane_busy;
    logic                r_out_valid;
    t_out                r_out, out_next;

    assign vec[0]  = r_item.vec_north;
    assign vec[1]  = r_item.vec_east;
    assign vec[2]  = r_item.vec_down;
    assign wind[0] = r_wind_n;
    assign wind[1] = r_wind_e;
    assign wind[2] = r_wind_d;

    // one lane per axis
    for (genvar g = 0; g < NUM_AX; g++) begin : g_lane
        pmi_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (ctl),
            .i_cfg     (lane_cfg),
            .i_vec     (vec[g]),
            .i_wind    (wind[g]),
            .i_dt      (r_item.time_step),
            .i_norm    (root),
            .i_pin_pos (g == NUM_AX - 1),
            .o_prod    (prod[g]),
            .o_stat    (st[g])
        );
    end

    assign lane_busy = st[0].busy | st[1].busy | st[2].busy;

    // merge: norm of the three lanes
    pmi_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (norm_go),
        .i_sq0   (prod[0]),
        .i_sq1   (prod[1]),
        .i_sq2   (prod[2]),
        .o_root  (root),
        .o_busy  (norm_busy)
    );

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_latch <= 1'b0;
        end else begin
            r_state <= n_state;
            r_latch <= n_latch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) r_item <= i_in_data;
    end

    // sequencer next state and lane commands
    always_comb begin
        n_state  = r_state;
        n_latch  = r_latch;
        ctl.op   = L_NOP;
        ctl.ground = 1'b0;
        norm_go  = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_DECODE;
            S_DECODE: begin
                n_state = S_IDLE;
                unique case (t_cmd'(r_item.command))
                    CMD_SET_VEL: if (!r_mode) ctl.op = L_SETV;
                    CMD_SET_FORCE: begin
                        if (r_mode) begin
                            ctl.op  = L_MUL_FORCE;
                            n_state = S_SETF;
                        end
                    end
                    CMD_TICK: begin
                        ctl.op  = L_MUL_DTV;
                        n_state = S_POS;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_SETF: begin
                ctl.op  = L_SETF;
                n_state = S_IDLE;
            end
            S_POS: begin
                ctl.op  = L_POS;
                n_state = r_mode ? S_DRAG_MUL : S_COPYV;
            end
            S_COPYV: begin
                ctl.op  = L_COPYV;
                n_state = (r_spd_lim > 0) ? S_SQ1 : S_GROUND;
            end
            S_SQ1: begin
                ctl.op  = L_MUL_SQ;
                n_state = S_NORM1_GO;
            end
            S_NORM1_GO: begin
                norm_go = 1'b1;
                n_state = S_NORM1_WAIT;
            end
            S_NORM1_WAIT: begin
                if (!norm_busy)
                    n_state = ({1'b0, root} > {1'b0, r_spd_lim}) ? S_CL_MUL : S_GROUND;
            end
            S_CL_MUL: begin
                ctl.op  = L_MUL_CLAMP;
                n_state = S_CL_DIV;
            end
            S_CL_DIV: begin
                ctl.op  = L_DIV_CLAMP;
                n_state = S_CL_WAIT;
            end
            S_CL_WAIT: begin
                if (!lane_busy) begin
                    ctl.op  = L_CLAMP_DONE;
                    n_state = S_GROUND;
                end
            end
            S_DRAG_MUL: begin
                ctl.op  = L_MUL_DRAG;
                n_state = S_ACC_DIV;
            end
            S_ACC_DIV: begin
                ctl.op  = L_DIV_ACC;
                n_state = S_ACC_WAIT;
            end
            S_ACC_WAIT: begin
                if (!lane_busy) begin
                    ctl.op  = L_ACC_DONE;
                    n_state = S_DTA_MUL;
                end
            end
            S_DTA_MUL: begin
                ctl.op  = L_MUL_DTA;
                n_state = S_VEL;
            end
            S_VEL: begin
                ctl.op  = L_VEL;
                n_state = S_GROUND;
            end
            S_GROUND: begin
                // latch on touchdown, release on upward demand
                n_latch    = r_latch ? !(st[2].df_neg || st[2].dv_neg)
                                     : (st[2].pos > 0);
                ctl.op     = L_GROUND;
                ctl.ground = n_latch;
                n_state    = S_SQ2;
            end
            S_SQ2: begin
                ctl.op  = L_MUL_SQ;
                n_state = S_NORM2_GO;
            end
            S_NORM2_GO: begin
                norm_go = 1'b1;
                n_state = S_NORM2_WAIT;
            end
            S_NORM2_WAIT: if (!norm_busy) n_state = S_OUT;
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    // result assembly
    always_comb begin
        out_next.pos_north    = st[0].pos;
        out_next.pos_east     = st[1].pos;
        out_next.pos_down     = st[2].pos;
        out_next.vel_north    = st[0].vel;
        out_next.vel_east     = st[1].vel;
        out_next.vel_down     = st[2].vel;
        out_next.acc_north    = r_mode ? st[0].acc : '0;
        out_next.acc_east     = r_mode ? st[1].acc : '0;
        out_next.acc_down     = r_mode ? f_sat_sub(st[2].acc, GRAVITY) : '0;
        out_next.on_ground    = r_latch;
        out_next.altitude     = f_sat_sub('0, st[2].pos);
        out_next.ground_speed = root[W-1] ? {(W-1){1'b1}} : root[W-2:0];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else          r_out_valid <= load_out || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (load_out) r_out <= out_next;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`include "assert_macros.svh"

    `ASSERT_IMP(a_div_in_wait, i_clk, i_rst_n, lane_busy,
        (r_state == S_CL_WAIT || r_state == S_ACC_WAIT))
    `ASSERT_IMP(a_norm_in_wait, i_clk, i_rst_n, norm_busy,
        (r_state == S_NORM1_WAIT || r_state == S_NORM2_WAIT))
    `ASSERT_IMP(a_ground_pinned, i_clk, i_rst_n, o_out_valid && o_out_data.on_ground,
        (o_out_data.pos_down == '0 && o_out_data.vel_north == '0 &&
         o_out_data.vel_east == '0 && o_out_data.vel_down == '0))
    `ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, load_out, o_out_valid)

endmodule
